// ===== rtl/core/mjdcal_pkg.sv =====
package mjdcal_pkg;

    localparam int unsigned MJD_W      = 16;
    localparam int unsigned UTC_W      = 40;
    localparam int unsigned NUM_W      = 20;
    localparam int unsigned YOFS_W     = 8;
    localparam int unsigned REM_W      = 10;
    localparam int unsigned MP_W       = 4;

    localparam int unsigned MJD_MIN    = 15079;
    localparam int unsigned MJD_BASE   = 14956;
    localparam int unsigned YEAR_BASE  = 1900;

    // y = (20*mjd - 301564) / 7305, done as multiply by ceil(2^33/7305)
    localparam int unsigned Y_MUL      = 20;
    localparam int unsigned Y_NUM_OFS  = 301564;
    localparam int unsigned Y_RECIP    = 1175898;
    localparam int unsigned Y_SHIFT    = 33;
    localparam int unsigned YD_MUL     = 1461;

    // mp = (10000*rem - 1000) / 306001, resolved by threshold compares
    localparam int unsigned MP_NUM     = 306001;
    localparam int unsigned MP_DEN     = 10000;
    localparam int unsigned MP_OFS     = 1000;
    localparam int unsigned MP_MAX     = 15;
    localparam int unsigned MONTHS     = 12;

    typedef struct packed {
        logic [7:0] hour;
        logic [7:0] minute;
        logic [7:0] second;
    } t_tod;

    // tens*10 + units, no digit check
    function automatic logic [7:0] bcd_pair(input logic [7:0] v);
        logic [7:0] tens;
        logic [7:0] units;
        tens  = 8'(v[7:4]);
        units = 8'(v[3:0]);
        return 8'(tens * 8'd10) + units;
    endfunction

endpackage

// ===== rtl/core/mjd_bcd_time_to_calendar.sv =====
// Broadcast UTC stamp to calendar date and time of day.
// Input channel: i_valid / o_ready with i_utc_time; bits 39..24 are the
// Modified Julian Date, bits 23..0 the BCD hh:mm:ss time of day.
// Output channel: o_valid / i_ready with year, month, day, hour, minute,
// second and date_valid. A transaction completes when valid and ready are
// both high at a rising edge of i_clk.
// Throughput is one transaction per cycle while i_ready stays high. The five
// stages are: BCD decode and year numerator, reciprocal multiply for the
// year, remaining days, month threshold search, day/month/year fixup into
// the output register.
// Each stage has its own valid bit and ready, so bubbles collapse while the
// receiver stalls; o_ready drops only once all five stages hold data.
// MJD below 15079 gives date_valid 0 and a zero date; time of day is still
// decoded. BCD digits above 9 are combined without a check.
// i_rst_n (synchronous, active low) empties the pipeline; no data is kept.
module mjd_bcd_time_to_calendar (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [39:0] i_utc_time,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [10:0] o_year,
    output logic [3:0]  o_month,
    output logic [4:0]  o_day,
    output logic [7:0]  o_hour,
    output logic [7:0]  o_minute,
    output logic [7:0]  o_second,
    output logic        o_date_valid
);
    import mjdcal_pkg::*;

    logic               f_valid;
    logic               f_ready;
    logic [MJD_W-1:0]   f_mjd;
    logic [NUM_W-1:0]   f_num;
    logic               f_ok;
    t_tod               f_tod;

    logic               y_valid;
    logic               y_ready;
    logic [YOFS_W-1:0]  y_yofs;
    logic [REM_W-1:0]   y_rem;
    logic               y_ok;
    t_tod               y_tod;

    t_tod               m_tod;

    mjdcal_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_utc_time (i_utc_time),
        .o_valid    (f_valid),
        .i_ready    (f_ready),
        .o_mjd      (f_mjd),
        .o_num      (f_num),
        .o_date_ok  (f_ok),
        .o_tod      (f_tod)
    );

    mjdcal_year u_year (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (f_valid),
        .o_ready    (f_ready),
        .i_mjd      (f_mjd),
        .i_num      (f_num),
        .i_date_ok  (f_ok),
        .i_tod      (f_tod),
        .o_valid    (y_valid),
        .i_ready    (y_ready),
        .o_yofs     (y_yofs),
        .o_rem      (y_rem),
        .o_date_ok  (y_ok),
        .o_tod      (y_tod)
    );

    mjdcal_month u_month (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (y_valid),
        .o_ready      (y_ready),
        .i_yofs       (y_yofs),
        .i_rem        (y_rem),
        .i_date_ok    (y_ok),
        .i_tod        (y_tod),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_year       (o_year),
        .o_month      (o_month),
        .o_day        (o_day),
        .o_tod        (m_tod),
        .o_date_valid (o_date_valid)
    );

    assign o_hour   = m_tod.hour;
    assign o_minute = m_tod.minute;
    assign o_second = m_tod.second;

endmodule

// ===== rtl/core/mjdcal_front.sv =====
module mjdcal_front (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic [39:0]                i_utc_time,
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic [15:0]                o_mjd,
    output logic [19:0]                o_num,
    output logic                       o_date_ok,
    output mjdcal_pkg::t_tod           o_tod
);
    import mjdcal_pkg::*;

    logic               r_vld;
    logic [MJD_W-1:0]   r_mjd;
    logic [NUM_W-1:0]   r_num;
    logic               r_ok;
    t_tod               r_tod;

    logic [MJD_W-1:0]   mjd;
    logic [NUM_W:0]     num_full;
    t_tod               n_tod;

    assign mjd      = i_utc_time[UTC_W-1:UTC_W-MJD_W];
    assign num_full = (NUM_W+1)'(mjd) * (NUM_W+1)'(Y_MUL) - (NUM_W+1)'(Y_NUM_OFS);

    always_comb begin
        n_tod.hour   = bcd_pair(i_utc_time[23:16]);
        n_tod.minute = bcd_pair(i_utc_time[15:8]);
        n_tod.second = bcd_pair(i_utc_time[7:0]);
    end

    assign o_ready = !r_vld || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_ready) begin
            r_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_mjd <= mjd;
            r_num <= num_full[NUM_W-1:0];
            r_ok  <= (mjd >= MJD_W'(MJD_MIN));
            r_tod <= n_tod;
        end
    end

    assign o_valid   = r_vld;
    assign o_mjd     = r_mjd;
    assign o_num     = r_num;
    assign o_date_ok = r_ok;
    assign o_tod     = r_tod;

endmodule

// ===== rtl/core/mjdcal_year.sv =====
module mjdcal_year (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic [15:0]                i_mjd,
    input  logic [19:0]                i_num,
    input  logic                       i_date_ok,
    input  mjdcal_pkg::t_tod           i_tod,
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic [7:0]                 o_yofs,
    output logic [9:0]                 o_rem,
    output logic                       o_date_ok,
    output mjdcal_pkg::t_tod           o_tod
);
    import mjdcal_pkg::*;

    localparam int unsigned PROD_W = NUM_W + 21;
    localparam int unsigned YD_W   = YOFS_W + 11;

    // stage A: year offset by reciprocal multiply
    logic               r_a_vld;
    logic [MJD_W-1:0]   r_a_mjd;
    logic [YOFS_W-1:0]  r_a_y;
    logic               r_a_ok;
    t_tod               r_a_tod;
    logic               a_ready;
    logic [PROD_W-1:0]  prod;

    // stage B: days left after the whole years
    logic               r_b_vld;
    logic [YOFS_W-1:0]  r_b_y;
    logic [REM_W-1:0]   r_b_rem;
    logic               r_b_ok;
    t_tod               r_b_tod;
    logic [YD_W-1:0]    yd_full;
    logic [MJD_W-1:0]   rem_full;
    logic               o_ready_b;

    assign prod = PROD_W'(i_num) * PROD_W'(Y_RECIP);

    assign a_ready = !r_a_vld || o_ready_b;
    assign o_ready = a_ready;

    assign o_ready_b = !r_b_vld || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
            r_b_vld <= 1'b0;
        end else begin
            if (a_ready) begin
                r_a_vld <= i_valid;
            end
            if (o_ready_b) begin
                r_b_vld <= r_a_vld;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && a_ready) begin
            r_a_mjd <= i_mjd;
            r_a_y   <= prod[Y_SHIFT +: YOFS_W];
            r_a_ok  <= i_date_ok;
            r_a_tod <= i_tod;
        end
    end

    // yd = floor(1461*y/4); rem stays in 123..488 for any accepted date
    assign yd_full  = YD_W'(r_a_y) * YD_W'(YD_MUL);
    assign rem_full = r_a_mjd - MJD_W'(MJD_BASE) - MJD_W'(yd_full >> 2);

    always_ff @(posedge i_clk) begin
        if (r_a_vld && o_ready_b) begin
            r_b_y   <= r_a_y;
            r_b_rem <= rem_full[REM_W-1:0];
            r_b_ok  <= r_a_ok;
            r_b_tod <= r_a_tod;
        end
    end

    assign o_valid   = r_b_vld;
    assign o_yofs    = r_b_y;
    assign o_rem     = r_b_rem;
    assign o_date_ok = r_b_ok;
    assign o_tod     = r_b_tod;

endmodule

// ===== rtl/core/mjdcal_month.sv =====
module mjdcal_month (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic [7:0]                 i_yofs,
    input  logic [9:0]                 i_rem,
    input  logic                       i_date_ok,
    input  mjdcal_pkg::t_tod           i_tod,
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic [10:0]                o_year,
    output logic [3:0]                 o_month,
    output logic [4:0]                 o_day,
    output mjdcal_pkg::t_tod           o_tod,
    output logic                       o_date_valid
);
    import mjdcal_pkg::*;

    // mp >= j  <=>  rem >= ceil((306001*j + 1000) / 10000)
    logic [REM_W-1:0]   th [1:MP_MAX];
    // floor(30.6001*mp)
    logic [REM_W-1:0]   fd [0:MP_MAX];

    for (genvar j = 1; j <= MP_MAX; j++) begin : g_th
        assign th[j] = REM_W'((MP_NUM * j + MP_OFS + MP_DEN - 1) / MP_DEN);
    end
    for (genvar j = 0; j <= MP_MAX; j++) begin : g_fd
        assign fd[j] = REM_W'((MP_NUM * j) / MP_DEN);
    end

    // stage C: month index
    logic               r_c_vld;
    logic [YOFS_W-1:0]  r_c_y;
    logic [REM_W-1:0]   r_c_rem;
    logic [MP_W-1:0]    r_c_mp;
    logic               r_c_ok;
    t_tod               r_c_tod;
    logic [MP_W-1:0]    mp;
    logic               c_ready;

    // stage D: output register
    logic               r_d_vld;
    logic [10:0]        r_d_year;
    logic [3:0]         r_d_month;
    logic [4:0]         r_d_day;
    logic               r_d_ok;
    t_tod               r_d_tod;
    logic               d_ready;

    logic               wrap;
    logic [YOFS_W-1:0]  yofs;
    logic [REM_W-1:0]   day_full;
    logic [MP_W-1:0]    month_full;
    logic [10:0]        n_year;
    logic [3:0]         n_month;
    logic [4:0]         n_day;

    always_comb begin
        mp = '0;
        for (int j = 1; j <= MP_MAX; j++) begin
            mp = mp + MP_W'(i_rem >= th[j]);
        end
    end

    assign d_ready = !r_d_vld || i_ready;
    assign c_ready = !r_c_vld || d_ready;
    assign o_ready = c_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_vld <= 1'b0;
            r_d_vld <= 1'b0;
        end else begin
            if (c_ready) begin
                r_c_vld <= i_valid;
            end
            if (d_ready) begin
                r_d_vld <= r_c_vld;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && c_ready) begin
            r_c_y   <= i_yofs;
            r_c_rem <= i_rem;
            r_c_mp  <= mp;
            r_c_ok  <= i_date_ok;
            r_c_tod <= i_tod;
        end
    end

    // months 14 and 15 belong to the next year
    always_comb begin
        wrap       = (r_c_mp == MP_W'(14)) || (r_c_mp == MP_W'(15));
        yofs       = r_c_y + YOFS_W'(wrap);
        day_full   = r_c_rem - fd[r_c_mp];
        month_full = r_c_mp - MP_W'(1) - (wrap ? MP_W'(MONTHS) : '0);
        if (!r_c_ok) begin
            n_year  = '0;
            n_month = '0;
            n_day   = '0;
        end else begin
            n_year  = (yofs == '0) ? '0 : 11'(yofs) + 11'(YEAR_BASE);
            n_month = month_full;
            n_day   = day_full[4:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_c_vld && d_ready) begin
            r_d_year  <= n_year;
            r_d_month <= n_month;
            r_d_day   <= n_day;
            r_d_ok    <= r_c_ok;
            r_d_tod   <= r_c_tod;
        end
    end

    assign o_valid      = r_d_vld;
    assign o_year       = r_d_year;
    assign o_month      = r_d_month;
    assign o_day        = r_d_day;
    assign o_tod        = r_d_tod;
    assign o_date_valid = r_d_ok;

endmodule

// ===== sim/calendar_checker.sv =====
`timescale 1ns / 1ps

// Watches both channels of the stamp converter, predicts the calendar fields
// of every accepted stamp and compares each returned transaction in order.
module calendar_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic [39:0] i_utc_time,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [10:0] i_year,
    input  logic [3:0]  i_month,
    input  logic [4:0]  i_day,
    input  logic [7:0]  i_hour,
    input  logic [7:0]  i_minute,
    input  logic [7:0]  i_second,
    input  logic        i_date_valid,
    output int          o_fail_count,
    output int          o_outstanding
);

    typedef struct packed {
        logic [10:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [7:0]  hour;
        logic [7:0]  minute;
        logic [7:0]  second;
        logic        date_valid;
    } t_calendar;

    t_calendar expected_dates[$];
    int        fail_total = 0;

    function automatic logic [7:0] digit_pair(input logic [7:0] bcd);
        return 8'(8'(bcd[7:4]) * 8'd10) + 8'(bcd[3:0]);
    endfunction

    function automatic t_calendar calendar_of_stamp(input logic [39:0] utc);
        t_calendar         cal;
        longint unsigned   mjd;
        longint unsigned   yofs;
        longint unsigned   ydays;
        longint unsigned   days_left;
        longint unsigned   mpos;
        longint unsigned   wrap;
        mjd        = longint'(utc[39:24]);
        cal.hour   = digit_pair(utc[23:16]);
        cal.minute = digit_pair(utc[15:8]);
        cal.second = digit_pair(utc[7:0]);
        if (mjd < 64'd15079) begin
            cal.year       = '0;
            cal.month      = '0;
            cal.day        = '0;
            cal.date_valid = 1'b0;
        end else begin
            yofs      = (64'd20 * mjd - 64'd301564) / 64'd7305;
            ydays     = (64'd1461 * yofs) >> 2;
            days_left = mjd - 64'd14956 - ydays;
            mpos      = (64'd10000 * days_left - 64'd1000) / 64'd306001;
            // Jan/Feb come out as months 14/15 of the previous year
            wrap      = (mpos == 64'd14 || mpos == 64'd15) ? 64'd1 : 64'd0;
            yofs      = yofs + wrap;
            cal.year  = (yofs != 0) ? 11'(yofs + 64'd1900) : 11'd0;
            cal.month = 4'(mpos - 64'd1 - 64'd12 * wrap);
            cal.day   = 5'(days_left - (64'd306001 * mpos) / 64'd10000);
            cal.date_valid = 1'b1;
        end
        return cal;
    endfunction

    function automatic int check_field(input string name, input logic [15:0] exp_val,
                                       input logic [15:0] act_val);
        if (act_val !== exp_val) begin
            $error("%s mismatch: expected %0d, got %0d", name, exp_val, act_val);
            return 1;
        end
        return 0;
    endfunction

    always @(posedge i_clk) begin
        t_calendar want;
        int        bad;
        if (i_rst_n) begin
            // pop before push so a spurious output never matches a fresh stamp
            if (i_out_valid && i_out_ready) begin
                if (expected_dates.size() == 0) begin
                    $error("unexpected result transaction");
                    fail_total++;
                end else begin
                    want = expected_dates.pop_front();
                    bad  = 0;
                    bad += check_field("year", 16'(want.year), 16'(i_year));
                    bad += check_field("month", 16'(want.month), 16'(i_month));
                    bad += check_field("day", 16'(want.day), 16'(i_day));
                    bad += check_field("hour", 16'(want.hour), 16'(i_hour));
                    bad += check_field("minute", 16'(want.minute), 16'(i_minute));
                    bad += check_field("second", 16'(want.second), 16'(i_second));
                    bad += check_field("date_valid", 16'(want.date_valid),
                                       16'(i_date_valid));
                    if (bad != 0) begin
                        fail_total++;
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                expected_dates.push_back(calendar_of_stamp(i_utc_time));
            end
        end
        o_fail_count  <= fail_total;
        o_outstanding <= expected_dates.size();
    end

endmodule

// ===== sim/mjd_bcd_time_to_calendar_tb.sv =====
`timescale 1ns / 1ps

module mjd_bcd_time_to_calendar_tb;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int RANDOM_ITEMS = 530;
    localparam int DRAIN_CYCLES = 12;

    localparam logic [39:0] DIRECTED_STAMPS [20] = '{
        {16'd0,     24'h000000},
        {16'd0,     24'hFFFFFF},
        {16'd15078, 24'h235959},
        {16'd15079, 24'h000000},
        {16'd15080, 24'h120030},
        {16'd15384, 24'h235959},
        {16'd15385, 24'h000001},
        {16'd15020, 24'h101010},
        {16'd51544, 24'h000000},
        {16'd51574, 24'h080808},
        {16'd51575, 24'h010203},
        {16'd51603, 24'h235960},
        {16'd51604, 24'h000000},
        {16'd51909, 24'h235959},
        {16'd58849, 24'h123456},
        {16'd65535, 24'hFFFFFF},
        {16'd32768, 24'hAAAAAA},
        {16'd32767, 24'h555555},
        {16'd1,     24'h9F9F9F},
        {16'd65534, 24'hA0B0C0}
    };

    logic        i_clk      = 1'b0;
    logic        i_rst_n    = 1'b0;
    logic        i_valid    = 1'b0;
    logic [mjdcal_pkg::UTC_W-1:0] i_utc_time = '0;
    logic        i_ready    = 1'b0;
    logic        o_ready;
    logic        o_valid;
    logic [10:0] o_year;
    logic [3:0]  o_month;
    logic [4:0]  o_day;
    logic [7:0]  o_hour;
    logic [7:0]  o_minute;
    logic [7:0]  o_second;
    logic        o_date_valid;

    int fail_count;
    int outstanding;
    int cycle_count = 0;
    int stamps_sent = 0;
    int results_taken = 0;
    int rx_hold = 0;

    always #6 i_clk = ~i_clk;

    mjd_bcd_time_to_calendar u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_utc_time   (i_utc_time),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_year       (o_year),
        .o_month      (o_month),
        .o_day        (o_day),
        .o_hour       (o_hour),
        .o_minute     (o_minute),
        .o_second     (o_second),
        .o_date_valid (o_date_valid)
    );

    calendar_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_valid),
        .i_in_ready    (o_ready),
        .i_utc_time    (i_utc_time),
        .i_out_valid   (o_valid),
        .i_out_ready   (i_ready),
        .i_year        (o_year),
        .i_month       (o_month),
        .i_day         (o_day),
        .i_hour        (o_hour),
        .i_minute      (o_minute),
        .i_second      (o_second),
        .i_date_valid  (o_date_valid),
        .o_fail_count  (fail_count),
        .o_outstanding (outstanding)
    );

    // Result side: random stall after each transaction, recurring no-stall
    // phases, and one long hold-off so the pipeline fills and o_ready drops.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (o_valid && i_ready) begin
                results_taken++;
                if (results_taken == 150) begin
                    rx_hold = 90;
                end else if ((results_taken / 60) % 4 == 1) begin
                    rx_hold = 0;
                end else begin
                    rx_hold = $urandom_range(0, 4);
                end
            end
            if (rx_hold > 0) begin
                i_ready <= 1'b0;
                rx_hold--;
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    // Called right after an edge; returns right after the accepting edge.
    task automatic send_stamp(input logic [39:0] stamp);
        int gap;
        if ((stamps_sent / 70) % 4 == 2) begin
            gap = 0;
        end else begin
            gap = $urandom_range(0, 4);
        end
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid    <= 1'b1;
        i_utc_time <= stamp;
        do begin
            @(posedge i_clk);
        end while (!o_ready);
        stamps_sent++;
    endtask

    function automatic logic [39:0] random_stamp();
        logic [15:0] mjd;
        logic [23:0] tod;
        int          pick;
        pick = $urandom_range(0, 9);
        case (pick)
            0: mjd = 16'($urandom_range(0, 15078));
            1: mjd = 16'($urandom);
            2: mjd = 16'($urandom_range(15060, 15420));
            default: mjd = 16'($urandom_range(15079, 65535));
        endcase
        if ($urandom_range(0, 1) == 0) begin
            tod = 24'($urandom);
        end else begin
            // valid BCD digits for hh:mm:ss; hours can reach 29
            tod = {4'($urandom_range(0, 2)), 4'($urandom_range(0, 9)),
                   4'($urandom_range(0, 5)), 4'($urandom_range(0, 9)),
                   4'($urandom_range(0, 5)), 4'($urandom_range(0, 9))};
        end
        return {mjd, tod};
    endfunction

    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("CHECK FAILED");
        $finish;
    end

    initial begin : stimulus
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        foreach (DIRECTED_STAMPS[idx]) begin
            send_stamp(DIRECTED_STAMPS[idx]);
        end
        repeat (RANDOM_ITEMS) begin
            send_stamp(random_stamp());
        end
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (outstanding != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

// ===== mjd_bcd_time_to_calendar.f =====
rtl/core/mjdcal_pkg.sv
rtl/core/mjdcal_front.sv
rtl/core/mjdcal_year.sv
rtl/core/mjdcal_month.sv
rtl/core/mjd_bcd_time_to_calendar.sv
sim/calendar_checker.sv
sim/mjd_bcd_time_to_calendar_tb.sv
